// ----- rtl/damage_region_tracker_defines.svh -----
// Assertion macros used by the damage region tracker engine.
`ifndef DAMAGE_REGION_TRACKER_DEFINES_SVH
`define DAMAGE_REGION_TRACKER_DEFINES_SVH

// Assert that a condition implies a consequence in the same cycle.
`define DRT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Assert that a condition implies a consequence in the next cycle.
`define DRT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- rtl/drt_pkg.sv -----
`default_nettype none
package drt_pkg;
	localparam int MAX_REGIONS = 32;
	localparam int COORD_BITS = 12;
	localparam int SIZE_BITS = COORD_BITS + 1;
	localparam int IDX_BITS = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int CNT_BITS = $clog2(MAX_REGIONS + 1);
	localparam int HELD_BITS = 6;
	localparam int FIFO_DEPTH = 2;

	localparam logic [1:0] CMD_ADD = 2'd0;
	localparam logic [1:0] CMD_QUERY = 2'd1;
	localparam logic [1:0] CMD_MARK = 2'd2;
	localparam logic [1:0] CMD_CLEAR = 2'd3;

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [SIZE_BITS-1:0] w;
		logic [SIZE_BITS-1:0] h;
	} box_t;

	typedef struct packed {
		logic [1:0] cmd;
		box_t       rect;
	} item_t;

	typedef struct packed {
		logic                 damaged;
		logic                 full_redraw_now;
		logic [HELD_BITS-1:0] regions_held;
	} result_t;

	function automatic logic overlap(box_t a, box_t b);
		logic [SIZE_BITS:0] ae, be, ab, bb;
		logic [SIZE_BITS:0] ax, bx, ay, by;
		ax = (SIZE_BITS+1)'(a.x);
		bx = (SIZE_BITS+1)'(b.x);
		ay = (SIZE_BITS+1)'(a.y);
		by = (SIZE_BITS+1)'(b.y);
		ae = ax + (SIZE_BITS+1)'(a.w);
		be = bx + (SIZE_BITS+1)'(b.w);
		ab = ay + (SIZE_BITS+1)'(a.h);
		bb = by + (SIZE_BITS+1)'(b.h);
		return (ax < be) && (bx < ae) && (ay < bb) && (by < ab);
	endfunction

	function automatic logic [COORD_BITS+SIZE_BITS-1:0] span(
		logic [COORD_BITS-1:0] ap, logic [SIZE_BITS-1:0] al,
		logic [COORD_BITS-1:0] bp, logic [SIZE_BITS-1:0] bl);
		logic [COORD_BITS-1:0] lo;
		logic [SIZE_BITS:0] ae, be, hi, l;
		logic [SIZE_BITS-1:0] len;
		lo = (ap < bp) ? ap : bp;
		ae = (SIZE_BITS+1)'(ap) + (SIZE_BITS+1)'(al);
		be = (SIZE_BITS+1)'(bp) + (SIZE_BITS+1)'(bl);
		hi = (ae > be) ? ae : be;
		l = hi - (SIZE_BITS+1)'(lo);
		len = l[SIZE_BITS] ? {SIZE_BITS{1'b1}} : l[SIZE_BITS-1:0];
		return {lo, len};
	endfunction
endpackage
`default_nettype wire

// ----- rtl/drt_front.sv -----
`default_nettype none
// Command queue between the input channel and the engine.
module drt_front import drt_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	output logic       full,
	input  wire item_t in_item,
	output logic       q_valid,
	output item_t      q_item,
	input  wire logic  q_take
);
	item_t mem_q [FIFO_DEPTH];
	logic [$clog2(FIFO_DEPTH)-1:0] wp_q, rp_q;
	logic [$clog2(FIFO_DEPTH):0] cnt_q;
	logic do_push, do_pop;

	assign full = (cnt_q == ($clog2(FIFO_DEPTH)+1)'(FIFO_DEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_item = mem_q[rp_q];
	assign do_push = push && !full;
	assign do_pop = q_take && q_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + ($clog2(FIFO_DEPTH)+1)'(do_push) - ($clog2(FIFO_DEPTH)+1)'(do_pop);
		end
	end
endmodule
`default_nettype wire

// ----- rtl/drt_engine.sv -----
`default_nettype none
`include "damage_region_tracker_defines.svh"
// Scans the region table entry by entry and applies each command.
module drt_engine import drt_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  q_valid,
	input  wire item_t q_item,
	output logic       q_take,
	output logic       res_valid,
	output result_t    res,
	input  wire logic  res_take
);
	typedef enum logic [2:0] {ST_IDLE, ST_READ, ST_CHECK, ST_WRITE, ST_DONE} state_t;

	state_t state_q;
	item_t item_q;
	box_t mem_q [MAX_REGIONS];
	box_t rd_q;
	logic [CNT_BITS-1:0] count_q, idx_q;
	logic full_redraw_q, damaged_q, hit_q;
	logic [IDX_BITS-1:0] wr_idx;
	box_t wr_box;
	logic wr_en;
	logic [COORD_BITS+SIZE_BITS-1:0] ux, uy;
	logic [HELD_BITS-1:0] held;

	assign ux = span(rd_q.x, rd_q.w, item_q.rect.x, item_q.rect.w);
	assign uy = span(rd_q.y, rd_q.h, item_q.rect.y, item_q.rect.h);
	assign q_take = (state_q == ST_IDLE);
	assign held = (count_q > CNT_BITS'(63)) ? HELD_BITS'(63) : HELD_BITS'(count_q);

	always_comb begin
		wr_en = (state_q == ST_WRITE);
		wr_idx = hit_q ? idx_q[IDX_BITS-1:0] : count_q[IDX_BITS-1:0];
		wr_box = hit_q ? box_t'{ux[SIZE_BITS+COORD_BITS-1:SIZE_BITS],
			uy[SIZE_BITS+COORD_BITS-1:SIZE_BITS],
			ux[SIZE_BITS-1:0], uy[SIZE_BITS-1:0]} : item_q.rect;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_idx] <= wr_box;
		end
		rd_q <= mem_q[idx_q[IDX_BITS-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			idx_q <= '0;
			full_redraw_q <= 1'b0;
			damaged_q <= 1'b0;
			hit_q <= 1'b0;
			res_valid <= 1'b0;
			res <= '0;
			item_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						item_q <= q_item;
						idx_q <= '0;
						hit_q <= 1'b0;
						damaged_q <= 1'b0;
						case (q_item.cmd)
							CMD_ADD: begin
								if (full_redraw_q) begin
									state_q <= ST_DONE;
								end else if (count_q >= CNT_BITS'(MAX_REGIONS)) begin
									full_redraw_q <= 1'b1;
									count_q <= '0;
									state_q <= ST_DONE;
								end else if (count_q == '0) begin
									state_q <= ST_WRITE;
								end else begin
									state_q <= ST_READ;
								end
							end
							CMD_QUERY: begin
								if (full_redraw_q) begin
									damaged_q <= 1'b1;
									state_q <= ST_DONE;
								end else if (count_q == '0) begin
									state_q <= ST_DONE;
								end else begin
									state_q <= ST_READ;
								end
							end
							CMD_MARK: begin
								full_redraw_q <= 1'b1;
								count_q <= '0;
								state_q <= ST_DONE;
							end
							default: begin
								full_redraw_q <= 1'b0;
								count_q <= '0;
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_READ: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (overlap(rd_q, item_q.rect)) begin
						if (item_q.cmd == CMD_ADD) begin
							hit_q <= 1'b1;
							state_q <= ST_WRITE;
						end else begin
							damaged_q <= 1'b1;
							state_q <= ST_DONE;
						end
					end else if (idx_q + 1'b1 >= count_q) begin
						state_q <= (item_q.cmd == CMD_ADD) ? ST_WRITE : ST_DONE;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= ST_READ;
					end
				end
				ST_WRITE: begin
					if (!hit_q) begin
						count_q <= count_q + 1'b1;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!res_valid || res_take) begin
						res_valid <= 1'b1;
						res <= '{damaged_q, full_redraw_q, held};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (res_valid && res_take && !(state_q == ST_DONE)) begin
				res_valid <= 1'b0;
			end
		end
	end

	`DRT_ASSERT_IMP(a_cnt_max, clk, arst_n, 1'b1, count_q <= CNT_BITS'(MAX_REGIONS))
	`DRT_ASSERT_IMP(a_full_empty, clk, arst_n, state_q == ST_IDLE && full_redraw_q,
		count_q == '0)
	`DRT_ASSERT_NXT(a_take, clk, arst_n, q_valid && state_q == ST_IDLE, state_q != ST_IDLE)
endmodule
`default_nettype wire

// ----- rtl/damage_region_tracker.sv -----
`default_nettype none
// Channel   Handshake          Payload
// input     push / full        cmd, rect_x, rect_y, rect_w, rect_h
// result    pop / empty        damaged, full_redraw_now, regions_held
//
// Add and query scan the stored rectangles entry by entry (read, then
// compare), and the engine takes no new transaction until its result is registered.
// Mark, clear, an add to a full table, and add or query on an empty table or under full redraw skip the scan.
// Reset clears the count and the full-redraw flag; the table needs no clearing.
// A two-entry queue takes transactions while the engine works; a held
// result stalls only the engine.
module damage_region_tracker import drt_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	output logic                       full,
	input  wire logic [1:0]            cmd,
	input  wire logic [COORD_BITS-1:0] rect_x,
	input  wire logic [COORD_BITS-1:0] rect_y,
	input  wire logic [SIZE_BITS-1:0]  rect_w,
	input  wire logic [SIZE_BITS-1:0]  rect_h,
	output logic                       empty,
	input  wire logic                  pop,
	output logic                       damaged,
	output logic                       full_redraw_now,
	output logic [HELD_BITS-1:0]       regions_held
);
	item_t in_item, q_item;
	logic q_valid, q_take, res_valid;
	result_t res;

	assign in_item = '{cmd, '{rect_x, rect_y, rect_w, rect_h}};

	// Front: queue of accepted commands.
	drt_front u_front (
		.clk, .arst_n, .push, .full, .in_item,
		.q_valid, .q_item, .q_take
	);

	// Back: table scan and update, with a registered result.
	drt_engine u_engine (
		.clk, .arst_n, .q_valid, .q_item, .q_take,
		.res_valid, .res, .res_take(pop)
	);

	assign empty = !res_valid;
	assign damaged = res.damaged;
	assign full_redraw_now = res.full_redraw_now;
	assign regions_held = res.regions_held;
endmodule
`default_nettype wire
